FILE: design/bxds_pkg.sv
// Shared types, register codes and constants of the box average downscaler.
package bxds_pkg;

  // Field and register widths fixed by the block's interface.
  localparam int SCALE_BITS     = 5;
  localparam int COL_CFG_BITS   = 13;
  localparam int ROW_CFG_BITS   = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int IN_PIXEL_BITS  = 16;
  localparam int SUM_BITS       = 16;
  localparam int ROW_POS_BITS   = 12;
  localparam int IN_BLOCK_BITS  = 4;
  localparam int DIVISOR_BITS   = 9;

  // Limits of the effective settings.
  localparam int MAX_SCALE = 16;
  localparam int MAX_ROWS  = 4096;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_COLUMNS = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROWS    = 2'd2;

  // Configuration reset values.
  localparam logic [SCALE_BITS-1:0]   SCALE_RESET   = 5'd2;
  localparam logic [COL_CFG_BITS-1:0] COLUMNS_RESET = 13'd640;
  localparam logic [ROW_CFG_BITS-1:0] ROWS_RESET    = 13'd480;

  // One input item.
  typedef struct packed {
    logic [IN_PIXEL_BITS-1:0] pixel_value;
    logic                     frame_start;
  } pix_in_t;

  // One result item.
  typedef struct packed {
    logic [SUM_BITS-1:0] scaled_pixel;
    logic                frame_end;
  } pix_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic lookup;
    logic update;
    logic emit_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic emit;
    logic out_free;
  } status_t;

endpackage

FILE: design/bxds_divider.sv
// Iterative restoring divider that retires one quotient bit per cycle.
module bxds_divider #(
  parameter int DW = 16,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic [VW-1:0] remainder,
  output logic          done
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvsr;
  logic [DW-1:0] quo;
  logic [CW-1:0] count;
  logic [VW:0]   trial;
  logic          fits;

  // Partial remainder with the next dividend bit shifted in.
  assign trial = {rem, quo[DW-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= CW'(DW);
    end else if (count != '0) begin
      count <= count - CW'(1);
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (load) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (count != '0) begin
      rem <= fits ? VW'(trial - {1'b0, dvsr}) : trial[VW-1:0];
      quo <= {quo[DW-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign done      = (count == '0);

  // A freshly loaded division is never reported finished at once.
  a_load_busy: assert property (@(posedge clk) disable iff (rst) load |=> !done)
    else $error("divider reports done right after load");

  // The final step leaves a remainder below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(1) && !load) |=> (rem < dvsr))
    else $error("divider remainder not below divisor");

endmodule

FILE: design/bxds_ctrl.sv
// Controller state machine that sequences clearing, division, lookup and output.
module bxds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bxds_pkg::status_t status,
  output bxds_pkg::cmd_t    cmd
);

  import bxds_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_next = status.emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall       = 1'b1;
    cmd            = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_load = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // An item leaves the emit state only by loading the output register.
  a_emit_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !status.out_free) |=> (state == ST_EMIT))
    else $error("result item dropped while output register was full");

  // An accepted item always enters the division phase.
  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_DIVIDE && !status.div_done))
    else $error("accepted item did not start division");

endmodule

FILE: design/bxds_datapath.sv
// Datapath: configuration, position counters, dividers, block sum memory and output register.
module bxds_datapath #(
  parameter int MAX_COLUMNS = 4096,
  parameter int PIXEL_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bxds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bxds_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  bxds_pkg::pix_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bxds_pkg::pix_out_t                  out_data,
  input  bxds_pkg::cmd_t                      cmd,
  output bxds_pkg::status_t                   status
);

  import bxds_pkg::*;

  localparam int COL_BITS = $clog2(MAX_COLUMNS);
  localparam int CNT_BITS = $clog2(MAX_COLUMNS + 1);
  localparam int W1       = (PIXEL_BITS > CNT_BITS) ? PIXEL_BITS : CNT_BITS;
  localparam int DIV_BITS = (W1 > ROW_CFG_BITS) ? W1 : ROW_CFG_BITS;

  // Configuration registers.
  logic [SCALE_BITS-1:0]   scale_factor;
  logic [COL_CFG_BITS-1:0] image_columns;
  logic [ROW_CFG_BITS-1:0] image_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor  <= SCALE_RESET;
      image_columns <= COLUMNS_RESET;
      image_rows    <= ROWS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SCALE:   scale_factor  <= cfg_data[SCALE_BITS-1:0];
        CFG_COLUMNS: image_columns <= cfg_data[COL_CFG_BITS-1:0];
        CFG_ROWS:    image_rows    <= cfg_data[ROW_CFG_BITS-1:0];
        default:     scale_factor  <= scale_factor;
      endcase
    end
  end

  // Effective settings with out-of-range values clamped.
  logic [SCALE_BITS-1:0]   s_eff;
  logic [CNT_BITS-1:0]     cols_eff;
  logic [ROW_CFG_BITS-1:0] rows_eff;
  logic [DIVISOR_BITS-1:0] s_square;

  always_comb begin
    if (scale_factor == '0) begin
      s_eff = SCALE_BITS'(1);
    end else if (scale_factor > SCALE_BITS'(MAX_SCALE)) begin
      s_eff = SCALE_BITS'(MAX_SCALE);
    end else begin
      s_eff = scale_factor;
    end
    if (image_columns == '0) begin
      cols_eff = CNT_BITS'(1);
    end else if (32'(image_columns) > MAX_COLUMNS) begin
      cols_eff = CNT_BITS'(MAX_COLUMNS);
    end else begin
      cols_eff = CNT_BITS'(image_columns);
    end
    if (image_rows == '0) begin
      rows_eff = ROW_CFG_BITS'(1);
    end else if (image_rows > ROW_CFG_BITS'(MAX_ROWS)) begin
      rows_eff = ROW_CFG_BITS'(MAX_ROWS);
    end else begin
      rows_eff = image_rows;
    end
    s_square = DIVISOR_BITS'(s_eff) * DIVISOR_BITS'(s_eff);
  end

  // Position counters.
  logic [COL_BITS-1:0]      column_position;
  logic [ROW_POS_BITS-1:0]  row_position;
  logic [IN_BLOCK_BITS-1:0] column_in_block;
  logic [IN_BLOCK_BITS-1:0] row_in_block;
  logic [COL_BITS-1:0]      column_position_next;
  logic [ROW_POS_BITS-1:0]  row_position_next;
  logic [IN_BLOCK_BITS-1:0] column_in_block_next;
  logic [IN_BLOCK_BITS-1:0] row_in_block_next;
  logic [CNT_BITS-1:0]      col_inc;
  logic [ROW_CFG_BITS-1:0]  row_inc;
  logic [IN_BLOCK_BITS:0]   cib_inc;
  logic [IN_BLOCK_BITS:0]   rib_inc;

  // Advance to the next raster position, wrapping at line and frame ends.
  always_comb begin
    col_inc              = CNT_BITS'(column_position) + CNT_BITS'(1);
    row_inc              = ROW_CFG_BITS'(row_position) + ROW_CFG_BITS'(1);
    cib_inc              = {1'b0, column_in_block} + (IN_BLOCK_BITS + 1)'(1);
    rib_inc              = {1'b0, row_in_block} + (IN_BLOCK_BITS + 1)'(1);
    column_in_block_next = (cib_inc >= s_eff) ? '0 : cib_inc[IN_BLOCK_BITS-1:0];
    column_position_next = col_inc[COL_BITS-1:0];
    row_in_block_next    = row_in_block;
    row_position_next    = row_position;
    if (col_inc >= cols_eff) begin
      column_position_next = '0;
      column_in_block_next = '0;
      row_in_block_next    = (rib_inc >= s_eff) ? '0 : rib_inc[IN_BLOCK_BITS-1:0];
      row_position_next    = row_inc[ROW_POS_BITS-1:0];
      if (row_inc >= rows_eff) begin
        row_position_next = '0;
        row_in_block_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
    end else if (cmd.accept && in_data.frame_start) begin
      column_position <= '0;
      row_position    <= '0;
      column_in_block <= '0;
      row_in_block    <= '0;
    end else if (cmd.update) begin
      column_position <= column_position_next;
      row_position    <= row_position_next;
      column_in_block <= column_in_block_next;
      row_in_block    <= row_in_block_next;
    end
  end

  // Dividers: pixel by scale squared, column by scale, sizes by scale.
  logic [COL_BITS-1:0]     col_now;
  logic [DIV_BITS-1:0]     q_pix;
  logic [DIV_BITS-1:0]     q_col;
  logic [DIV_BITS-1:0]     q_cols;
  logic [DIVISOR_BITS-1:0] r_rows;
  logic                    done_pix;
  logic                    done_col;
  logic                    done_cols;
  logic                    done_rows;
  logic                    div_done;

  assign col_now  = in_data.frame_start ? '0 : column_position;
  assign div_done = done_pix & done_col & done_cols & done_rows;

  bxds_divider #(.DW(DIV_BITS), .VW(DIVISOR_BITS)) u_div_pix (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.accept),
    .dividend  (DIV_BITS'(in_data.pixel_value[PIXEL_BITS-1:0])),
    .divisor   (s_square),
    .quotient  (q_pix),
    .remainder (),
    .done      (done_pix)
  );

  bxds_divider #(.DW(DIV_BITS), .VW(DIVISOR_BITS)) u_div_col (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.accept),
    .dividend  (DIV_BITS'(col_now)),
    .divisor   (DIVISOR_BITS'(s_eff)),
    .quotient  (q_col),
    .remainder (),
    .done      (done_col)
  );

  bxds_divider #(.DW(DIV_BITS), .VW(DIVISOR_BITS)) u_div_cols (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.accept),
    .dividend  (DIV_BITS'(cols_eff)),
    .divisor   (DIVISOR_BITS'(s_eff)),
    .quotient  (q_cols),
    .remainder (),
    .done      (done_cols)
  );

  bxds_divider #(.DW(DIV_BITS), .VW(DIVISOR_BITS)) u_div_rows (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.accept),
    .dividend  (DIV_BITS'(rows_eff)),
    .divisor   (DIVISOR_BITS'(s_eff)),
    .quotient  (),
    .remainder (r_rows),
    .done      (done_rows)
  );

  // Block decisions taken once the quotients are ready.
  logic [CNT_BITS-1:0] whole_cols;
  logic                active_now;
  logic                emit_now;
  logic                last_now;
  logic [COL_BITS-1:0] idx;
  logic                active;
  logic                first;
  logic                emit;
  logic                last;

  always_comb begin
    whole_cols = q_cols[CNT_BITS-1:0] * CNT_BITS'(s_eff);
    active_now = (r_rows == '0) && (CNT_BITS'(column_position) < whole_cols);
    emit_now   = active_now
              && ({1'b0, row_in_block} == s_eff - SCALE_BITS'(1))
              && ({1'b0, column_in_block} == s_eff - SCALE_BITS'(1));
    last_now   = (ROW_CFG_BITS'(row_position) == rows_eff - ROW_CFG_BITS'(1))
              && (CNT_BITS'(column_position) == whole_cols - CNT_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      idx    <= q_col[COL_BITS-1:0];
      active <= active_now;
      first  <= (row_in_block == '0) && (column_in_block == '0);
      emit   <= emit_now;
      last   <= last_now;
    end
  end

  // Clearing pass over the block sum memory after reset.
  logic [COL_BITS-1:0] clear_addr;
  logic                clear_done;

  assign clear_done = (clear_addr == COL_BITS'(MAX_COLUMNS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_step && !clear_done) begin
      clear_addr <= clear_addr + COL_BITS'(1);
    end
  end

  // Block sum memory: one write port, one registered read port.
  logic [SUM_BITS-1:0] block_sums [MAX_COLUMNS];
  logic [SUM_BITS-1:0] rd_data;
  logic [SUM_BITS-1:0] sum_now;
  logic [SUM_BITS-1:0] sum;

  assign sum_now = first ? SUM_BITS'(q_pix[PIXEL_BITS-1:0])
                         : rd_data + SUM_BITS'(q_pix[PIXEL_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      block_sums[clear_addr] <= '0;
    end else if (cmd.update && active) begin
      block_sums[idx] <= sum_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rd_data <= block_sums[q_col[COL_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      sum <= sum_now;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_data.scaled_pixel <= sum;
      out_data.frame_end    <= last;
    end
  end

  // Status to the controller.
  always_comb begin
    status.clear_done = clear_done;
    status.div_done   = div_done;
    status.emit       = emit;
    status.out_free   = !out_valid || !out_stall;
  end

  // Lookup uses the quotients only after every divider has finished.
  a_lookup_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.lookup |-> div_done)
    else $error("block lookup before division finished");

endmodule

FILE: design/box_average_downscaler_core.sv
// Top level of the box average downscaler: controller and datapath.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  pix_in_t  (pixel_value, frame_start)
//   out      output     out_valid/out_stall pix_out_t (scaled_pixel, frame_end)
//   cfg      input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item at a time: each item is accepted, divided by the bit-serial dividers, which retire one
// quotient bit per cycle, then looked up and updated in the block sum memory, and emitted when it
// produces a result (their width DIV_BITS is the widest of PIXEL_BITS, the column count width and 13).
// After reset a clearing pass zeroes the block sum memory; no item is accepted during it, while
// configuration writes are taken at any time.
// A result waits in the output register under out_stall while the next item is accepted.
module box_average_downscaler_core #(
  parameter int MAX_COLUMNS = 4096,
  parameter int PIXEL_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bxds_pkg::pix_in_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bxds_pkg::pix_out_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bxds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bxds_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import bxds_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  bxds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  bxds_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
